@@ rtl/core/bni_pkg.sv @@
// Package for the batch normalization inference block.
// Holds the item structs, the controller state type and the command and status groups.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bni_pkg;
    localparam int DATA_W = 32;
    localparam int EPS_W  = 16;

    typedef struct packed {
        logic signed [DATA_W-1:0] x_value;
        logic                     first_of_channel;
        logic signed [DATA_W-1:0] gain;
        logic signed [DATA_W-1:0] offset;
        logic signed [DATA_W-1:0] mean_in;
        logic        [DATA_W-1:0] variance;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] y_value;
        logic                     saturated;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_FACT,
        S_DIFF,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_ch;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic fact;
        logic diff;
        logic mul;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic first;
    } t_status;
endpackage
`default_nettype wire

@@ rtl/core/batch_norm_inference.sv @@
// Top level of the batch normalization inference block.
// Joins bni_ctrl and bni_datapath; depends on bni_pkg.
//
// Items enter on i_in_item with i_in_valid and are taken when o_in_stall is low.
// The item that opens a channel carries gain, offset, mean and variance.
// Results leave on o_out_item with o_out_valid; the receiver holds i_out_stall
// high to keep a result in the output register.
// The epsilon register is written on i_cfg_data with i_cfg_valid; o_cfg_ready
// is always high.
// An ordinary element passes S_DIFF, S_MUL and S_OUT into the output register, and
// the next item can be taken back in S_IDLE, so such elements pass one at a time.
// A channel-opening element first passes S_LOAD, R = ceil((33 + FRAC_BITS) / 2)
// steps of the bit-serial square root, S_DINIT, N = 32 + FRAC_BITS steps of the
// restoring divider and S_FACT, one bit per cycle each in root and divider.
// One item is worked on at a time; the next one is accepted once the result has
// entered the output register.
// Reset zeroes the mean, offset and factor, sets epsilon to one, clears output valid.
// While the receiver stalls with a full output register the block holds its
// finished result and accepts no further item.
`timescale 1ns / 1ps
`default_nettype none
module batch_norm_inference #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  bni_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output bni_pkg::t_out_item             o_out_item,
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic [bni_pkg::EPS_W-1:0] i_cfg_data
);
    import bni_pkg::*;

    localparam int SQRT_STEPS = (DATA_W + 1 + FRAC_BITS + 1) / 2;
    localparam int DIV_STEPS  = DATA_W + FRAC_BITS;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    bni_ctrl #(
        .SQRT_STEPS(SQRT_STEPS),
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    bni_datapath #(
        .FRAC_BITS(FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cfg_valid(i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_item (o_out_item)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted item");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an item in work");

    a_idle_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_in_stall) |=> !o_out_valid)
        else $error("result repeated while idle");
endmodule
`default_nettype wire

@@ rtl/core/bni_ctrl.sv @@
// Controller state machine of the batch normalization block.
// Sequences root, divide and element steps; depends on bni_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bni_ctrl #(
    parameter int SQRT_STEPS = 25,
    parameter int DIV_STEPS  = 48
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    input  bni_pkg::t_status    i_status,
    output bni_pkg::t_cmd       o_cmd
);
    import bni_pkg::*;

    localparam int MAX_STEPS = (SQRT_STEPS > DIV_STEPS) ? SQRT_STEPS : DIV_STEPS;
    localparam int CW = $clog2(MAX_STEPS + 1);

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic w_accept, w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_status.first ? S_LOAD : S_DIFF;
                end
            end
            S_LOAD: begin
                n_state = S_SQRT;
                n_cnt   = CW'(SQRT_STEPS - 1);
            end
            S_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = S_DINIT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DINIT: begin
                n_state = S_DIV;
                n_cnt   = CW'(DIV_STEPS - 1);
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_FACT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FACT:  n_state = S_DIFF;
            S_DIFF:  n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = w_accept;
        o_cmd.load_ch   = (r_state == S_LOAD);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.div_init  = (r_state == S_DINIT);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.fact      = (r_state == S_FACT);
        o_cmd.diff      = (r_state == S_DIFF);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.load_out  = (r_state == S_OUT) && w_out_free;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

@@ rtl/core/bni_datapath.sv @@
// Datapath of the batch normalization block: bit-serial root and divider,
// channel registers, element multiply and saturation; depends on bni_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bni_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  bni_pkg::t_in_item           i_in_item,
    input  wire logic                   i_cfg_valid,
    input  wire logic [bni_pkg::EPS_W-1:0] i_cfg_data,
    input  bni_pkg::t_cmd               i_cmd,
    output bni_pkg::t_status            o_status,
    output bni_pkg::t_out_item          o_out_item
);
    import bni_pkg::*;

    localparam int SW  = DATA_W + 1 + FRAC_BITS;
    localparam int RW  = (SW + 1) / 2;
    localparam int NPW = 2 * RW;
    localparam int NW  = DATA_W + FRAC_BITS;
    localparam int PW  = 2 * DATA_W + 1;
    localparam logic [NW-1:0] SMAX_Q = NW'({1'b0, {(DATA_W-1){1'b1}}});
    localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    t_in_item r_item;
    logic [EPS_W-1:0] r_eps;
    logic signed [DATA_W-1:0] r_factor, r_mean, r_bias, r_gain;
    logic r_fsat;
    logic [NPW-1:0] r_sq_src;
    logic [RW:0] r_sq_rem;
    logic [RW-1:0] r_sq_root;
    logic [NW-1:0] r_dv_num;
    logic [RW-1:0] r_dv_rem;
    logic signed [DATA_W:0] r_diff;
    logic signed [PW-1:0] r_prod;
    t_out_item r_out;

    logic [DATA_W:0] w_sum_s;
    logic [RW+2:0] w_sq_rem2, w_sq_trial;
    logic [RW:0] w_dv_rem2;
    logic [DATA_W-1:0] w_gmag;
    logic signed [PW-FRAC_BITS:0] w_y;
    logic w_hi, w_lo;

    assign w_sum_s    = {1'b0, i_in_item.variance} + (DATA_W+1)'(r_eps);
    assign w_sq_rem2  = {r_sq_rem, r_sq_src[NPW-1:NPW-2]};
    assign w_sq_trial = {1'b0, r_sq_root, 2'b01};
    assign w_dv_rem2  = {r_dv_rem, r_dv_num[NW-1]};
    assign w_gmag     = r_gain[DATA_W-1] ? DATA_W'(-r_gain) : DATA_W'(r_gain);
    assign w_y        = (PW-FRAC_BITS+1)'(r_prod >>> FRAC_BITS) + (PW-FRAC_BITS+1)'(r_bias);
    assign w_hi       = w_y > (PW-FRAC_BITS+1)'(SMAX);
    assign w_lo       = w_y < (PW-FRAC_BITS+1)'(SMIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps    <= EPS_W'(1);
            r_factor <= '0;
            r_mean   <= '0;
            r_bias   <= '0;
            r_fsat   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_eps <= i_cfg_data;
            end
            if (i_cmd.load_ch) begin
                r_mean <= r_item.mean_in;
                r_bias <= r_item.offset;
            end
            if (i_cmd.fact) begin
                r_fsat <= 1'b0;
                if (r_sq_root == '0) begin
                    r_fsat   <= 1'b1;
                    r_factor <= r_gain[DATA_W-1] ? SMIN : ((r_gain == '0) ? '0 : SMAX);
                end else if (r_gain[DATA_W-1]) begin
                    if (r_dv_num > SMAX_Q + 1'b1) begin
                        r_fsat   <= 1'b1;
                        r_factor <= SMIN;
                    end else begin
                        r_factor <= DATA_W'(-r_dv_num);
                    end
                end else begin
                    if (r_dv_num > SMAX_Q) begin
                        r_fsat   <= 1'b1;
                        r_factor <= SMAX;
                    end else begin
                        r_factor <= DATA_W'(r_dv_num);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_item;
            r_sq_src  <= NPW'({w_sum_s, {FRAC_BITS{1'b0}}});
            r_sq_rem  <= '0;
            r_sq_root <= '0;
        end
        if (i_cmd.load_ch) begin
            r_gain <= r_item.gain;
        end
        if (i_cmd.sqrt_step) begin
            r_sq_src <= {r_sq_src[NPW-3:0], 2'b00};
            if (w_sq_rem2 >= w_sq_trial) begin
                r_sq_rem  <= (RW+1)'(w_sq_rem2 - w_sq_trial);
                r_sq_root <= {r_sq_root[RW-2:0], 1'b1};
            end else begin
                r_sq_rem  <= (RW+1)'(w_sq_rem2);
                r_sq_root <= {r_sq_root[RW-2:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_dv_num <= NW'({w_gmag, {FRAC_BITS{1'b0}}});
            r_dv_rem <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_dv_rem2 >= {1'b0, r_sq_root}) begin
                r_dv_rem <= RW'(w_dv_rem2 - {1'b0, r_sq_root});
                r_dv_num <= {r_dv_num[NW-2:0], 1'b1};
            end else begin
                r_dv_rem <= RW'(w_dv_rem2);
                r_dv_num <= {r_dv_num[NW-2:0], 1'b0};
            end
        end
        if (i_cmd.diff) begin
            r_diff <= (DATA_W+1)'(r_item.x_value) - (DATA_W+1)'(r_mean);
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_diff * r_factor);
        end
        if (i_cmd.load_out) begin
            r_out.y_value   <= w_hi ? SMAX : (w_lo ? SMIN : DATA_W'(w_y));
            r_out.saturated <= w_hi || w_lo || r_fsat;
        end
    end

    assign o_status.first = i_in_item.first_of_channel;
    assign o_out_item     = r_out;
endmodule
`default_nettype wire
